// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the sequencer rtl
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that implies a property in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// ===== rtl/core/ptms_pkg.sv =====
// types and constants of the periodic turn motor sequencer
// used by every module in rtl/core; no dependencies
package ptms_pkg;

    // register widths
    localparam int PERIOD_W = 26;
    localparam int TURNS_W  = 4;
    localparam int REV_W    = 16;
    localparam int PMIN_W   = 8;
    localparam int CFG_W    = 26;
    localparam int CFG_IDX_W = 2;

    // state widths
    localparam int SINCE_W = 16;
    localparam int ROT_W   = 16;

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PMIN    = 2'd3;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 26'd1800000;
    localparam logic [TURNS_W-1:0]  TURNS_RST   = 4'd3;
    localparam logic [REV_W-1:0]    REVERSE_RST = 16'd100;
    localparam logic [PMIN_W-1:0]   PMIN_RST    = 8'd1;

    // mode codes
    localparam logic MODE_WAIT = 1'b0;
    localparam logic MODE_TURN = 1'b1;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TURNS_W-1:0]  turns;
        logic [REV_W-1:0]    reverse;
        logic [PMIN_W-1:0]   pmin;
    } ptms_cfg_t;

    typedef struct packed {
        logic [ROT_W-1:0] rotations_done;
        logic             turning;
        logic             at_position;
        logic             drive_left;
        logic             drive_right;
    } ptms_result_t;

endpackage

// ===== rtl/core/ptms_cfg.sv =====
// configuration registers of the sequencer
// depends on ptms_pkg
module ptms_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ptms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptms_pkg::CFG_W-1:0]        cfg_data,
    output ptms_pkg::ptms_cfg_t               cfg
);

    ptms_pkg::ptms_cfg_t cfg_reg;
    ptms_pkg::ptms_cfg_t cfg_next;

    // decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ptms_pkg::REG_PERIOD:  cfg_next.period  = cfg_data[ptms_pkg::PERIOD_W-1:0];
                ptms_pkg::REG_TURNS:   cfg_next.turns   = cfg_data[ptms_pkg::TURNS_W-1:0];
                ptms_pkg::REG_REVERSE: cfg_next.reverse = cfg_data[ptms_pkg::REV_W-1:0];
                ptms_pkg::REG_PMIN:    cfg_next.pmin    = cfg_data[ptms_pkg::PMIN_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period  <= ptms_pkg::PERIOD_RST;
            cfg_reg.turns   <= ptms_pkg::TURNS_RST;
            cfg_reg.reverse <= ptms_pkg::REVERSE_RST;
            cfg_reg.pmin    <= ptms_pkg::PMIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/ptms_step.sv =====
// per-tick sequencer state and next-state logic
// depends on ptms_pkg and assert_macros.svh
`include "assert_macros.svh"

module ptms_step
#(
    parameter int TIMER_WIDTH = 26
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    input  logic                        level,
    input  ptms_pkg::ptms_cfg_t         cfg,
    output ptms_pkg::ptms_result_t      result
);

    localparam int CMP_W = (TIMER_WIDTH > ptms_pkg::PERIOD_W) ? TIMER_WIDTH : ptms_pkg::PERIOD_W;
    localparam logic [TIMER_WIDTH-1:0]       TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [ptms_pkg::SINCE_W-1:0] SINCE_MAX = {ptms_pkg::SINCE_W{1'b1}};
    localparam logic [ptms_pkg::ROT_W-1:0]   ROT_MAX   = {ptms_pkg::ROT_W{1'b1}};

    logic                          mode_reg, mode_next;
    logic [TIMER_WIDTH-1:0]        wait_timer_reg, wait_timer_next;
    logic                          in_pos_reg, in_pos_next;
    logic [ptms_pkg::TURNS_W-1:0]  turn_count_reg, turn_count_next;
    logic                          seen_low_reg, seen_low_next;
    logic [ptms_pkg::SINCE_W-1:0]  since_low_reg, since_low_next;
    logic [ptms_pkg::ROT_W-1:0]    rot_count_reg, rot_count_next;
    logic                          right_reg, right_next;
    logic                          left_reg, left_next;

    logic [TIMER_WIDTH-1:0]        timer_inc;
    logic [ptms_pkg::SINCE_W-1:0]  since_inc;
    logic [CMP_W-1:0]              timer_cmp;
    logic [CMP_W-1:0]              period_cmp;

    // saturating increments
    assign timer_inc  = (wait_timer_reg != TIMER_MAX) ? wait_timer_reg + 1'b1 : wait_timer_reg;
    assign since_inc  = (since_low_reg != SINCE_MAX) ? since_low_reg + 1'b1 : since_low_reg;
    assign timer_cmp  = CMP_W'(timer_inc);
    assign period_cmp = CMP_W'(cfg.period);

    // next state for one tick
    always_comb
    begin
        mode_next       = mode_reg;
        wait_timer_next = wait_timer_reg;
        in_pos_next     = in_pos_reg;
        turn_count_next = turn_count_reg;
        seen_low_next   = seen_low_reg;
        since_low_next  = since_low_reg;
        rot_count_next  = rot_count_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        if (tick)
        begin
            if (mode_reg == ptms_pkg::MODE_WAIT)
            begin
                wait_timer_next = timer_inc;
                right_next      = !level;
                in_pos_next     = level;
                if ((timer_cmp > period_cmp) && level)
                begin
                    mode_next       = ptms_pkg::MODE_TURN;
                    turn_count_next = '0;
                    seen_low_next   = 1'b0;
                    since_low_next  = '0;
                    right_next      = 1'b1;
                end
            end
            else
            begin
                since_low_next = since_inc;
                // pulse counting while turns remain
                if (turn_count_reg < cfg.turns)
                begin
                    if (!level)
                    begin
                        seen_low_next  = 1'b1;
                        since_low_next = '0;
                    end
                    else if (seen_low_reg &&
                             (since_inc > ptms_pkg::SINCE_W'(cfg.pmin)))
                    begin
                        seen_low_next   = 1'b0;
                        turn_count_next = turn_count_reg + 1'b1;
                    end
                end
                // reverse phase and end of cycle
                if (turn_count_next >= cfg.turns)
                begin
                    right_next = 1'b0;
                    left_next  = 1'b1;
                    if (since_low_next > cfg.reverse)
                    begin
                        if (rot_count_reg != ROT_MAX)
                        begin
                            rot_count_next = rot_count_reg + 1'b1;
                        end
                        left_next       = 1'b0;
                        mode_next       = ptms_pkg::MODE_WAIT;
                        wait_timer_next = '0;
                        in_pos_next     = 1'b0;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ptms_pkg::MODE_WAIT;
            wait_timer_reg <= '0;
            in_pos_reg     <= 1'b0;
            turn_count_reg <= '0;
            seen_low_reg   <= 1'b0;
            since_low_reg  <= '0;
            rot_count_reg  <= '0;
            right_reg      <= 1'b0;
            left_reg       <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            wait_timer_reg <= wait_timer_next;
            in_pos_reg     <= in_pos_next;
            turn_count_reg <= turn_count_next;
            seen_low_reg   <= seen_low_next;
            since_low_reg  <= since_low_next;
            rot_count_reg  <= rot_count_next;
            right_reg      <= right_next;
            left_reg       <= left_next;
        end
    end

    // result of the tick taken this cycle
    assign result.drive_right    = right_next;
    assign result.drive_left     = left_next;
    assign result.at_position    = in_pos_next;
    assign result.turning        = mode_next;
    assign result.rotations_done = rot_count_next;

    // checks
    `ASSERT_HOLDS(a_drives_exclusive, clk, rst_n, !(right_reg && left_reg), "both drives on")
    `ASSERT_HOLDS(a_wait_no_left, clk, rst_n, (mode_reg == ptms_pkg::MODE_TURN) || !left_reg, "left drive on in wait")
    `ASSERT_NEXT(a_rot_monotonic, clk, rst_n, 1'b1, rot_count_reg >= $past(rot_count_reg), "rotation count fell")

endmodule

// ===== rtl/core/ptms_skid.sv =====
// output register with one skid entry for the result stream
// depends on ptms_pkg and assert_macros.svh
`include "assert_macros.svh"

module ptms_skid
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ptms_pkg::ptms_result_t      in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ptms_pkg::ptms_result_t      out_data
);

    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    ptms_pkg::ptms_result_t out_data_reg, out_data_next;
    ptms_pkg::ptms_result_t skid_data_reg, skid_data_next;
    logic                   accept;
    logic                   out_free;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // route new request to output or skid entry; a parked skid entry moves to the output first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                if (accept)
                begin
                    out_data_next = in_data;
                end
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `ASSERT_HOLDS(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg, "skid entry without output")
    `ASSERT_NEXT(a_stall_keeps_out, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg, "stalled result lost")
    `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, out_valid_reg && !out_ready && accept, skid_valid_reg, "request dropped on stall")

endmodule

// ===== rtl/core/periodic_turn_motor_sequencer_top.sv =====
// each result is registered in the output register, or in the skid entry on a stall
// throughput: one tick per clock cycle while s_tready is high
// a stalled output parks one result in a skid entry before s_tready drops
// reset (rst_n low, asynchronous) clears all state but the result payload and loads register defaults
// depends on ptms_pkg, ptms_cfg, ptms_step, ptms_skid
module periodic_turn_motor_sequencer_top
#(
    parameter int TIMER_WIDTH = 26
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptms_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] opto_level
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] drive_right, [1] drive_left, [2] at_position, [3] turning, [19:4] rotations_done
    output logic [ptms_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [ptms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptms_pkg::CFG_W-1:0]        cfg_data
);

    ptms_pkg::ptms_cfg_t    cfg;
    ptms_pkg::ptms_result_t step_result;
    ptms_pkg::ptms_result_t out_result;
    logic                   tick;

    assign tick = s_tvalid && s_tready;

    // configuration registers
    ptms_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer state
    ptms_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .level  (s_tdata[0]),
        .cfg    (cfg),
        .result (step_result)
    );

    // result buffering
    ptms_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // pack result fields
    assign m_tdata = {4'd0, out_result.rotations_done, out_result.turning,
                      out_result.at_position, out_result.drive_left, out_result.drive_right};

endmodule

// ===== bench/ptms_checker.sv =====
// checker for the periodic turn motor sequencer: watches tick, result and register ports
// keeps its own copy of the sequencer state and compares every result; needs ptms_pkg
`timescale 1ns / 1ps

module ptms_checker
#(
    parameter int TIMER_WIDTH = 26
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [ptms_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] opto_level
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] drive_right, [1] drive_left, [2] at_position, [3] turning, [19:4] rotations_done
    input  logic [ptms_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [ptms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptms_pkg::CFG_W-1:0]        cfg_data,
    output int                                mismatches,
    output int                                pending
);

    // predicted sequencer state and register copy
    ptms_pkg::ptms_cfg_t              settings;
    logic                             mode;
    logic [TIMER_WIDTH-1:0]           wait_timer;
    logic                             in_position;
    logic [ptms_pkg::TURNS_W-1:0]     turn_count;
    logic                             seen_low;
    logic [ptms_pkg::SINCE_W-1:0]     since_low;
    logic [ptms_pkg::ROT_W-1:0]       rotation_count;
    logic                             right_on;
    logic                             left_on;

    // expected results still owed by the block, oldest first
    ptms_pkg::ptms_result_t expected_drive[$];

    // one millisecond tick of the sequencer
    task automatic advance_sequencer(input logic level, output ptms_pkg::ptms_result_t res);
        if (mode == ptms_pkg::MODE_WAIT)
        begin
            if (wait_timer != {TIMER_WIDTH{1'b1}})
                wait_timer = wait_timer + 1'b1;
            right_on    = ~level;
            in_position = level;
            if (wait_timer > settings.period && in_position)
            begin
                mode       = ptms_pkg::MODE_TURN;
                turn_count = '0;
                seen_low   = 1'b0;
                since_low  = '0;
                right_on   = 1'b1;
            end
        end
        else
        begin
            if (since_low != {ptms_pkg::SINCE_W{1'b1}})
                since_low = since_low + 1'b1;
            // pulses are only counted until the target is reached
            if (turn_count < settings.turns)
            begin
                if (!level)
                begin
                    seen_low  = 1'b1;
                    since_low = '0;
                end
                if (level && seen_low && since_low > ptms_pkg::SINCE_W'(settings.pmin))
                begin
                    seen_low   = 1'b0;
                    turn_count = turn_count + 1'b1;
                end
            end
            // reverse phase, ends once the low has aged past the reverse time
            if (turn_count >= settings.turns)
            begin
                right_on = 1'b0;
                left_on  = 1'b1;
                if (since_low > settings.reverse)
                begin
                    if (rotation_count != {ptms_pkg::ROT_W{1'b1}})
                        rotation_count = rotation_count + 1'b1;
                    left_on     = 1'b0;
                    mode        = ptms_pkg::MODE_WAIT;
                    wait_timer  = '0;
                    in_position = 1'b0;
                end
            end
        end
        res.drive_right    = right_on;
        res.drive_left     = left_on;
        res.at_position    = in_position;
        res.turning        = mode;
        res.rotations_done = rotation_count;
    endtask

    function automatic int field_differs(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    initial mismatches = 0;

    // predict on each tick request, compare on each result, track register writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        ptms_pkg::ptms_result_t want;
        ptms_pkg::ptms_result_t got;
        if (!rst_n)
        begin
            settings       = '{period: ptms_pkg::PERIOD_RST, turns: ptms_pkg::TURNS_RST,
                               reverse: ptms_pkg::REVERSE_RST, pmin: ptms_pkg::PMIN_RST};
            mode           = ptms_pkg::MODE_WAIT;
            wait_timer     = '0;
            in_position    = 1'b0;
            turn_count     = '0;
            seen_low       = 1'b0;
            since_low      = '0;
            rotation_count = '0;
            right_on       = 1'b0;
            left_on        = 1'b0;
            expected_drive.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_sequencer(s_tdata[0], want);
                expected_drive.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(ptms_pkg::ptms_result_t)-1:0];
                if (expected_drive.size() == 0)
                begin
                    $error("result 0x%0h offered with no tick waiting", got);
                    mismatches++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    mismatches += field_differs("drive_right", 16'(want.drive_right),
                                                16'(got.drive_right));
                    mismatches += field_differs("drive_left", 16'(want.drive_left),
                                                16'(got.drive_left));
                    mismatches += field_differs("at_position", 16'(want.at_position),
                                                16'(got.at_position));
                    mismatches += field_differs("turning", 16'(want.turning),
                                                16'(got.turning));
                    mismatches += field_differs("rotations_done", want.rotations_done,
                                                got.rotations_done);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ptms_pkg::REG_PERIOD:  settings.period  = cfg_data[ptms_pkg::PERIOD_W-1:0];
                    ptms_pkg::REG_TURNS:   settings.turns   = cfg_data[ptms_pkg::TURNS_W-1:0];
                    ptms_pkg::REG_REVERSE: settings.reverse = cfg_data[ptms_pkg::REV_W-1:0];
                    ptms_pkg::REG_PMIN:    settings.pmin    = cfg_data[ptms_pkg::PMIN_W-1:0];
                    default:               ;
                endcase
            end
            pending <= expected_drive.size();
        end
    end

endmodule

// ===== bench/tb_periodic_turn_motor_sequencer_top.sv =====
// testbench top for the periodic turn motor sequencer: clock, reset, sensor tick stimulus
// and register settings; results are judged by ptms_checker; needs ptms_pkg and the rtl
`timescale 1ns / 1ps

module tb_periodic_turn_motor_sequencer_top;

    localparam int TIMER_WIDTH = 26;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 200;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ptms_pkg::IN_DATA_W-1:0]  s_tdata;    // [0] opto_level
    logic                            m_tvalid;
    logic                            m_tready;
    // [0] drive_right, [1] drive_left, [2] at_position, [3] turning, [19:4] rotations_done
    logic [ptms_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_we;
    logic [ptms_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ptms_pkg::CFG_W-1:0]      cfg_data;

    int   errors;
    int   pending;
    int   idle_level = 0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   cur_pmin   = 1;
    int   ticks_sent = 0;
    int   settings_loaded = 0;
    int   cycles     = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    periodic_turn_motor_sequencer_top #(.TIMER_WIDTH(TIMER_WIDTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptms_checker #(.TIMER_WIDTH(TIMER_WIDTH)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (errors),
        .pending    (pending)
    );

    // run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("periodic_turn_motor_sequencer_top test failed");
            $finish;
        end
    end

    // result side: random hold-offs, plus one long stall to back the block up
    initial
    begin : result_sink
        int held;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end
            else if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 9 : 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // one tick request, with an optional gap in front of it
    task automatic send_tick(input logic level);
        if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 9 : 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ptms_pkg::IN_DATA_W-1){1'b0}}, level};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        ticks_sent++;
    endtask

    // sensor levels taken lsb first
    task automatic send_levels(input logic [31:0] levels, input int count);
        for (int i = 0; i < count; i++)
            send_tick(levels[i]);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ptms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptms_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // all four registers, sometimes with junk above the turns, reverse and pmin field widths
    task automatic load_setting(input int period, input int turns,
                                input int reverse, input int pmin);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
        drain();
        write_reg(ptms_pkg::REG_PERIOD, ptms_pkg::CFG_W'(ptms_pkg::PERIOD_W'(period)));
        write_reg(ptms_pkg::REG_TURNS, ptms_pkg::CFG_W'({junk, ptms_pkg::TURNS_W'(turns)}));
        write_reg(ptms_pkg::REG_REVERSE, ptms_pkg::CFG_W'({junk, ptms_pkg::REV_W'(reverse)}));
        write_reg(ptms_pkg::REG_PMIN, ptms_pkg::CFG_W'({junk, ptms_pkg::PMIN_W'(pmin)}));
        cfg_we <= 1'b0;
        cur_pmin = pmin & 8'hFF;
        settings_loaded++;
    endtask

    // sensor pulse trains around the pulse width limit, with some noise mixed in
    task automatic play_random(input int count);
        int   left;
        int   run;
        logic level;
        left  = count;
        level = 1'($urandom_range(0, 1));
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                send_tick(1'($urandom_range(0, 1)));
                left--;
            end
            else
            begin
                if (!level)
                    run = $urandom_range(1, 3);
                else if ($urandom_range(0, 1) == 1)
                    run = $urandom_range(cur_pmin + 1, cur_pmin + 3);
                else
                    run = $urandom_range(1, cur_pmin + 1);
                while (run > 0 && left > 0)
                begin
                    send_tick(level);
                    run--;
                    left--;
                end
                level = ~level;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = ptms_pkg::REG_PERIOD;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: wait mode just follows the sensor
        send_levels(32'b1010, 4);
        // zero period, zero turns: reverse starts and ends at once
        load_setting(0, 0, 0, 0);
        send_levels(32'b01011, 5);
        // single turn with a pulse that is first too short, then long enough
        load_setting(2, 1, 1, 1);
        send_levels(32'b111110111, 9);
        // every register at its top value: the period never runs out
        load_setting({ptms_pkg::PERIOD_W{1'b1}}, 15, 65535, 255);
        send_levels(32'b101, 3);

        // random phases over a spread of settings and idling
        for (int p = 0; p < 12; p++)
        begin
            idle_level = p % 3;
            case (p)
                0:       load_setting(0, 1, 3, 255);
                1:       load_setting(1, 15, 5, 0);
                2:       load_setting(0, 2, 65535, 1);
                3:       load_setting($urandom_range(0, 20), 0, $urandom_range(0, 30),
                                      $urandom_range(0, 4));
                4:       load_setting({ptms_pkg::PERIOD_W{1'b1}}, $urandom_range(1, 15),
                                      $urandom_range(0, 30), $urandom_range(0, 4));
                default: load_setting($urandom_range(0, 30), $urandom_range(0, 15),
                                      $urandom_range(0, 40), $urandom_range(0, 5));
            endcase
            if (p == 3)
                hold_req = 1'b1;
            play_random(p == 0 ? 400 : 130);
        end

        // closing stretch without idling
        idle_level = 0;
        load_setting($urandom_range(0, 10), $urandom_range(1, 4), $urandom_range(0, 10),
                     $urandom_range(0, 3));
        play_random(60);

        drain();
        repeat (10) @(posedge clk);
        $display("sent %0d sensor ticks under %0d register settings, incl. a long output stall",
                 ticks_sent, settings_loaded + 1);
        $display("and pulse trains around the minimum width, zero-turn and top-value settings");
        if (errors == 0)
            $display("periodic_turn_motor_sequencer_top test passed");
        else
            $display("periodic_turn_motor_sequencer_top test failed");
        $finish;
    end

endmodule
